[src/box_filter_mipmap_chain_defines.svh]
// Assertion macros used by the mip chain top level.
`ifndef BOX_FILTER_MIPMAP_CHAIN_DEFINES_SVH
`define BOX_FILTER_MIPMAP_CHAIN_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BFM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BFM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/bfm_pkg.sv]
// Package: constants, types and helpers of the box filter mip chain.
package bfm_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_LEVELS = 10;
    localparam int STOP_SIZE  = 4;
    localparam int NUM_CELLS  = MAX_LEVELS + 1;
    localparam int LINE_AW    = $clog2(MAX_WIDTH);
    localparam int PAIR_W     = 36;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_CELL,
        S_MIX,
        S_DIVGO,
        S_DIVW,
        S_SUM,
        S_END
    } state_t;

    typedef enum logic [1:0] {
        K_STOP,
        K_HOLD,
        K_WRITE,
        K_READ
    } kind_t;

    typedef struct packed {
        logic [12:0] w;
        logic [12:0] h;
        logic [12:0] off;
        logic        en;
    } geo_t;

    typedef struct packed {
        kind_t               kind;
        logic [LINE_AW-1:0]  idx;
        logic [PAIR_W-1:0]   pairs;
        logic [10:0]         col;
        logic [10:0]         row;
        logic                at_end;
        logic                home;
    } act_t;

    function automatic logic [12:0] clamp_size(input logic [12:0] v);
        logic [12:0] r;
        r = v;
        if (v == 13'd0)
            r = 13'd1;
        else if (v > 13'(MAX_WIDTH))
            r = 13'(MAX_WIDTH);
        return r;
    endfunction

endpackage

[src/box_filter_mipmap_chain.sv]
// Top level: box filter mip chain with average color summary.
//
//  channel  | dir | beat contents (low bits first)
//  ---------+-----+---------------------------------------------------------
//  s_axis   | in  | tdata: red, green, blue, alpha
//  m_axis   | out | tdata: level, column, row, red, green, blue, alpha;
//           |     | tuser: transparent; tlast: last result of the pixel
//  cfg      | in  | cfg_index selects image_width / image_height
//
//  One pixel is in flight at a time. For every mip level it completes, a pixel
//  takes one cell step plus a line store read.
//  The first pixel of an image first loads level geometry down the cell chain;
//  the final pixel adds the 32-step divider.
//  Reset clears all counters, sums and geometry; the line store is not cleared.
//  A stalled m_axis holds the chain once both result registers are full.
module box_filter_mipmap_chain (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // level, column, row, red, green, blue, alpha
    output logic        m_axis_tuser,   // transparent
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

`include "box_filter_mipmap_chain_defines.svh"

    localparam int NC = bfm_pkg::NUM_CELLS;

    bfm_pkg::state_t state_reg;
    bfm_pkg::state_t state_next;

    logic [12:0]      width_reg;
    logic [12:0]      height_reg;
    logic [3:0]       cur_reg;
    logic [3:0]       step_reg;
    logic [31:0]      tok_reg;
    logic             fin_reg;
    logic [3:0][31:0] sums_reg;
    logic [35:0]      mpairs_reg;
    logic [10:0]      mcol_reg;
    logic [10:0]      mrow_reg;

    // pending result: held until it is known whether another follows
    logic             p_valid_reg;
    logic [57:0]      p_data_reg;
    logic             p_user_reg;

    logic             o_valid_reg;
    logic [63:0]      o_data_reg;
    logic             o_user_reg;
    logic             o_last_reg;

    bfm_pkg::geo_t    geo_in [NC];
    bfm_pkg::geo_t    geo    [NC];
    bfm_pkg::geo_t    child  [NC];
    bfm_pkg::act_t    act    [NC];
    bfm_pkg::act_t    act_cur;
    bfm_pkg::geo_t    seed;

    logic             in_beat;
    logic             cfg_beat;
    logic             cfg_hit;
    logic             start_img;
    logic             fin_now;
    logic             o_free;
    logic             can_push;
    logic             push_mix;
    logic             push_sum;
    logic             flush_end;
    logic             o_load;
    logic             cell_load;
    logic             ram_we;
    logic             ram_re;
    logic             div_start;
    logic             div_busy;
    logic [3:0][7:0]  quo;
    logic [35:0]      ram_rdata;
    logic [31:0]      npix;
    logic [9:0]       qsum;
    logic [3:0]       mix_level;
    logic [57:0]      sum_data;

    assign act_cur   = act[cur_reg];
    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_beat &&
                       (cfg_index == bfm_pkg::REG_WIDTH || cfg_index == bfm_pkg::REG_HEIGHT);
    assign start_img = act[0].home;
    assign fin_now   = (cur_reg == 4'd0) ? act_cur.at_end : fin_reg;
    assign o_free    = !o_valid_reg || m_axis_tready;
    assign can_push  = !p_valid_reg || o_free;

    // Seed geometry for the base level, clamped to the supported range.
    always_comb
    begin
        seed.w   = bfm_pkg::clamp_size(width_reg);
        seed.h   = bfm_pkg::clamp_size(height_reg);
        seed.off = '0;
        seed.en  = 1'b1;
    end

    // Cell chain: each cell hands its derived geometry to the next level.
    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign geo_in[i] = seed;
        end
        else
        begin : g_link
            assign geo_in[i] = child[i-1];
        end

        bfm_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .load   (cell_load),
            .clr    (cell_load || (i == 0 && cfg_hit)),
            .go     (state_reg == bfm_pkg::S_CELL && cur_reg == 4'(i)),
            .geo_in (geo_in[i]),
            .pix    (tok_reg),
            .geo    (geo[i]),
            .child  (child[i]),
            .act    (act[i])
        );
    end

    bfm_ram #(
        .WIDTH (bfm_pkg::PAIR_W),
        .DEPTH (bfm_pkg::MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (act_cur.idx),
        .wdata (act_cur.pairs),
        .re    (ram_re),
        .raddr (act_cur.idx),
        .rdata (ram_rdata)
    );

    bfm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sums_reg),
        .wid   (geo[0].w),
        .hgt   (geo[0].h),
        .busy  (div_busy),
        .quo   (quo)
    );

    // Finish the 2x2 mean: stored pair sums from the row above plus this row.
    always_comb
    begin
        npix = '0;
        for (int c = 0; c < 4; c++)
        begin
            qsum = {1'b0, ram_rdata[9*c +: 9]} + {1'b0, mpairs_reg[9*c +: 9]};
            npix[8*c +: 8] = qsum[9:2];
        end
        mix_level = cur_reg + 4'd1;
        sum_data  = {quo[3], quo[2], quo[1], quo[0], 11'd0, 11'd0, 4'd0};
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfm_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = start_img ? bfm_pkg::S_SETUP : bfm_pkg::S_CELL;
            end
            bfm_pkg::S_SETUP:
            begin
                if (step_reg == 4'(bfm_pkg::MAX_LEVELS))
                    state_next = bfm_pkg::S_CELL;
            end
            bfm_pkg::S_CELL:
            begin
                if (act_cur.kind == bfm_pkg::K_READ)
                    state_next = bfm_pkg::S_MIX;
                else
                    state_next = fin_now ? bfm_pkg::S_DIVGO : bfm_pkg::S_END;
            end
            bfm_pkg::S_MIX:
            begin
                if (can_push)
                    state_next = bfm_pkg::S_CELL;
            end
            bfm_pkg::S_DIVGO:
            begin
                state_next = bfm_pkg::S_DIVW;
            end
            bfm_pkg::S_DIVW:
            begin
                if (!div_busy)
                    state_next = bfm_pkg::S_SUM;
            end
            bfm_pkg::S_SUM:
            begin
                if (can_push)
                    state_next = bfm_pkg::S_END;
            end
            bfm_pkg::S_END:
            begin
                if (!p_valid_reg || o_free)
                    state_next = bfm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bfm_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        cell_load     = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        div_start     = 1'b0;
        push_mix      = 1'b0;
        push_sum      = 1'b0;
        flush_end     = 1'b0;
        case (state_reg)
            bfm_pkg::S_IDLE:  s_axis_tready = 1'b1;
            bfm_pkg::S_SETUP: cell_load     = 1'b1;
            bfm_pkg::S_CELL:
            begin
                ram_we = (act_cur.kind == bfm_pkg::K_WRITE);
                ram_re = (act_cur.kind == bfm_pkg::K_READ);
            end
            bfm_pkg::S_MIX:   push_mix  = can_push;
            bfm_pkg::S_DIVGO: div_start = 1'b1;
            bfm_pkg::S_SUM:   push_sum  = can_push;
            bfm_pkg::S_END:   flush_end = p_valid_reg && o_free;
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
        // a new result releases the held one as not-last; the end releases it as last
        o_load = ((push_mix || push_sum) && p_valid_reg) || flush_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bfm_pkg::S_IDLE;
            width_reg   <= 13'd256;
            height_reg  <= 13'd256;
            cur_reg     <= '0;
            step_reg    <= '0;
            fin_reg     <= 1'b0;
            sums_reg    <= '0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_beat && cfg_index == bfm_pkg::REG_WIDTH)
                width_reg <= cfg_data;
            if (cfg_beat && cfg_index == bfm_pkg::REG_HEIGHT)
                height_reg <= cfg_data;

            if (in_beat)
            begin
                cur_reg  <= '0;
                step_reg <= '0;
                for (int c = 0; c < 4; c++)
                begin
                    sums_reg[c] <= (start_img ? 32'd0 : sums_reg[c]) +
                                   {24'd0, s_axis_tdata[8*c +: 8]};
                end
            end
            if (cell_load)
                step_reg <= step_reg + 4'd1;
            if (state_reg == bfm_pkg::S_CELL && cur_reg == 4'd0)
                fin_reg <= act_cur.at_end;
            if (push_mix)
                cur_reg <= mix_level;

            if (push_mix || push_sum)
                p_valid_reg <= 1'b1;
            else if (flush_end)
                p_valid_reg <= 1'b0;

            if (o_load)
                o_valid_reg <= 1'b1;
            else if (m_axis_tready)
                o_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_beat)
            tok_reg <= s_axis_tdata;
        else if (push_mix)
            tok_reg <= npix;
        if (state_reg == bfm_pkg::S_CELL)
        begin
            mpairs_reg <= act_cur.pairs;
            mcol_reg   <= act_cur.col;
            mrow_reg   <= act_cur.row;
        end
        if (push_mix)
        begin
            p_data_reg <= {npix, mrow_reg, mcol_reg, mix_level};
            p_user_reg <= 1'b0;
        end
        else if (push_sum)
        begin
            p_data_reg <= sum_data;
            p_user_reg <= (quo[3] != 8'hFF);
        end
        if (o_load)
        begin
            o_data_reg <= {6'd0, p_data_reg};
            o_user_reg <= p_user_reg;
            o_last_reg <= flush_end;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = o_data_reg;
    assign m_axis_tuser  = o_user_reg;
    assign m_axis_tlast  = o_last_reg;

    `BFM_ASSERT_NOW(a_idle_no_pending, state_reg == bfm_pkg::S_IDLE, !p_valid_reg, "result left pending at idle")
    `BFM_ASSERT_NOW(a_ram_one_port, 1'b1, !(ram_we && ram_re), "line store read and write together")
    `BFM_ASSERT_NEXT(a_read_then_mix, ram_re, state_reg == bfm_pkg::S_MIX, "line read not followed by mix")
    `BFM_ASSERT_NOW(a_cur_range, state_reg == bfm_pkg::S_CELL, cur_reg <= 4'(bfm_pkg::MAX_LEVELS), "cell pointer past chain")

endmodule

[src/bfm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bfm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/bfm_cell.sv]
// One mip level cell: geometry, position counters, left pixel hold.
module bfm_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic          clr,
    input  logic          go,
    input  bfm_pkg::geo_t geo_in,
    input  logic [31:0]   pix,
    output bfm_pkg::geo_t geo,
    output bfm_pkg::geo_t child,
    output bfm_pkg::act_t act
);

    bfm_pkg::geo_t geo_reg;
    logic [11:0]   col_reg;
    logic [11:0]   col_next;
    logic [11:0]   row_reg;
    logic [11:0]   row_next;
    logic [31:0]   left_reg;
    logic [12:0]   x13;
    logic [12:0]   y13;
    logic [12:0]   idx13;
    logic [12:0]   side;
    logic          wrap_x;
    logic          wrap_y;
    logic          in_rng;

    always_comb
    begin
        x13    = {1'b0, col_reg};
        y13    = {1'b0, row_reg};
        wrap_x = (x13 + 13'd1) >= geo_reg.w;
        wrap_y = (y13 + 13'd1) >= geo_reg.h;
        col_next = wrap_x ? 12'd0 : col_reg + 12'd1;
        if (wrap_x)
            row_next = wrap_y ? 12'd0 : row_reg + 12'd1;
        else
            row_next = row_reg;
        in_rng = (x13 < {geo_reg.w[12:1], 1'b0}) && (y13 < {geo_reg.h[12:1], 1'b0});

        side      = (geo_reg.w < geo_reg.h) ? geo_reg.w : geo_reg.h;
        child.w   = {1'b0, geo_reg.w[12:1]};
        child.h   = {1'b0, geo_reg.h[12:1]};
        child.off = geo_reg.off + {1'b0, geo_reg.w[12:1]};
        child.en  = geo_reg.en && (side > 13'(bfm_pkg::STOP_SIZE));

        idx13 = geo_reg.off + {2'b00, col_reg[11:1]};
        for (int c = 0; c < 4; c++)
        begin
            act.pairs[9*c +: 9] = {1'b0, left_reg[8*c +: 8]} + {1'b0, pix[8*c +: 8]};
        end
        act.idx    = idx13[bfm_pkg::LINE_AW-1:0];
        act.col    = col_reg[11:1];
        act.row    = row_reg[11:1];
        act.at_end = wrap_x && wrap_y;
        act.home   = (col_reg == 12'd0) && (row_reg == 12'd0);
        // The last cell never produces: its side is at most the stop size.
        if (!child.en || !in_rng)
            act.kind = bfm_pkg::K_STOP;
        else if (!col_reg[0])
            act.kind = bfm_pkg::K_HOLD;
        else if (idx13 >= 13'(bfm_pkg::MAX_WIDTH))
            act.kind = bfm_pkg::K_STOP;
        else if (row_reg[0])
            act.kind = bfm_pkg::K_READ;
        else
            act.kind = bfm_pkg::K_WRITE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geo_reg  <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                geo_reg <= geo_in;
            end
            if (clr)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (go)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (go && act.kind == bfm_pkg::K_HOLD)
            begin
                left_reg <= pix;
            end
        end
    end

    assign geo = geo_reg;

endmodule

[src/bfm_div.sv]
// Four-lane restoring divider for the average color, one bit per cycle.
module bfm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [3:0][31:0]  num,
    input  logic [12:0]       wid,
    input  logic [12:0]       hgt,
    output logic              busy,
    output logic [3:0][7:0]   quo
);

    logic              busy_reg;
    logic [5:0]        cnt_reg;
    logic [25:0]       den_reg;
    logic [3:0][31:0]  q_reg;
    logic [3:0][25:0]  rem_reg;
    logic [3:0][26:0]  trial;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            trial[c] = {rem_reg[c], q_reg[c][31]} - {1'b0, den_reg};
            quo[c]   = (|q_reg[c][31:8]) ? 8'hFF : q_reg[c][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= wid * hgt;
            q_reg   <= num;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (!trial[c][26])
                begin
                    rem_reg[c] <= trial[c][25:0];
                    q_reg[c]   <= {q_reg[c][30:0], 1'b1};
                end
                else
                begin
                    rem_reg[c] <= {rem_reg[c][24:0], q_reg[c][31]};
                    q_reg[c]   <= {q_reg[c][30:0], 1'b0};
                end
            end
        end
    end

    assign busy = busy_reg;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the box filter mip chain: directed images, then random images.
`timescale 1ns / 100ps

module tb;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 100;   // covers the divider and a full level cascade
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic [3:0]  level;
        logic [10:0] column;
        logic [10:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        transparent;
        logic        last;
    } mip_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;

    box_filter_mipmap_chain dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: registers, level geometry, counters and sums.
    // ------------------------------------------------------------------
    logic [12:0] width_reg = 13'd256;
    logic [12:0] height_reg = 13'd256;
    int unsigned lvl_cols [0:bfm_pkg::MAX_LEVELS];
    int unsigned lvl_rows [0:bfm_pkg::MAX_LEVELS];
    int unsigned lvl_base [0:bfm_pkg::MAX_LEVELS];
    int unsigned col_pos [0:bfm_pkg::MAX_LEVELS];
    int unsigned row_pos [0:bfm_pkg::MAX_LEVELS];
    logic [31:0] left_pixel [0:bfm_pkg::MAX_LEVELS-1];
    logic [35:0] pair_line [0:bfm_pkg::MAX_WIDTH-1];
    int unsigned chan_sum [0:3];
    int unsigned levels_live;

    mip_beat_t   mip_expected [$];
    logic [31:0] pixel_queue [$];

    int unsigned pixels_sent;
    int unsigned beats_checked;
    int unsigned deepest_level;
    int unsigned mismatch_count;
    int unsigned error_count;
    int unsigned cycle_count;
    bit          quiet;           // no idling on either side
    int unsigned hold_requests;   // bumped to ask the receiver for a long hold-off
    bit          pixel_taken;

    function automatic int unsigned clamp_dim(input logic [12:0] v);
        if (v == 0)
            return 1;
        if (v > bfm_pkg::MAX_WIDTH)
            return bfm_pkg::MAX_WIDTH;
        return v;
    endfunction

    function automatic void start_image();
        int unsigned w;
        int unsigned h;
        lvl_cols[0] = clamp_dim(width_reg);
        lvl_rows[0] = clamp_dim(height_reg);
        lvl_base[0] = 0;
        levels_live = 0;
        while (levels_live < bfm_pkg::MAX_LEVELS)
        begin
            w = lvl_cols[levels_live];
            h = lvl_rows[levels_live];
            if ((w < h ? w : h) <= bfm_pkg::STOP_SIZE)
                break;
            lvl_cols[levels_live+1] = w / 2;
            lvl_rows[levels_live+1] = h / 2;
            lvl_base[levels_live+1] = lvl_base[levels_live] + w / 2;
            levels_live++;
        end
        for (int c = 0; c < 4; c++)
            chan_sum[c] = 0;
        for (int i = 0; i <= bfm_pkg::MAX_LEVELS; i++)
        begin
            col_pos[i] = 0;
            row_pos[i] = 0;
        end
    endfunction

    function automatic void apply_register(input logic [1:0] idx, input logic [12:0] val);
        if (idx == bfm_pkg::REG_WIDTH)
            width_reg = val;
        else if (idx == bfm_pkg::REG_HEIGHT)
            height_reg = val;
        else
            return;
        // A width or height write abandons the image in progress.
        col_pos[0] = 0;
        row_pos[0] = 0;
    endfunction

    // Work out every beat one base pixel produces and queue them up.
    function automatic void predict_mip_beats(input logic [31:0] pixel_in);
        logic [31:0] pix;
        logic [31:0] npix;
        logic [35:0] pairs;
        logic [35:0] stored;
        int unsigned lv;
        int unsigned x;
        int unsigned y;
        int unsigned idx;
        int unsigned count;
        int unsigned avg;
        int unsigned produced;
        bit          final_pixel;
        mip_beat_t   b;

        pix = pixel_in;
        produced = 0;
        if (col_pos[0] == 0 && row_pos[0] == 0)
            start_image();
        for (int c = 0; c < 4; c++)
            chan_sum[c] += pix[8*c +: 8];
        final_pixel = (col_pos[0] + 1 >= lvl_cols[0]) && (row_pos[0] + 1 >= lvl_rows[0]);

        lv = 0;
        while (1)
        begin
            x = col_pos[lv];
            y = row_pos[lv];
            if (x + 1 >= lvl_cols[lv])
            begin
                col_pos[lv] = 0;
                row_pos[lv] = (y + 1 >= lvl_rows[lv]) ? 0 : y + 1;
            end
            else
            begin
                col_pos[lv] = x + 1;
            end
            if (lv >= levels_live)
                break;
            // Drop an odd last column or row.
            if (x >= 2 * lvl_cols[lv+1] || y >= 2 * lvl_rows[lv+1])
                break;
            if (x % 2 == 0)
            begin
                left_pixel[lv] = pix;
                break;
            end
            for (int c = 0; c < 4; c++)
                pairs[9*c +: 9] = 9'(left_pixel[lv][8*c +: 8]) + 9'(pix[8*c +: 8]);
            idx = lvl_base[lv] + x / 2;
            if (idx >= bfm_pkg::MAX_WIDTH)
                break;
            if (y % 2 == 0)
            begin
                pair_line[idx] = pairs;
                break;
            end
            stored = pair_line[idx];
            for (int c = 0; c < 4; c++)
                npix[8*c +: 8] = 8'((10'(stored[9*c +: 9]) + 10'(pairs[9*c +: 9])) >> 2);
            b.level = 4'(lv + 1);
            b.column = 11'(x / 2);
            b.row = 11'(y / 2);
            {b.alpha, b.blue, b.green, b.red} = npix;
            b.transparent = 1'b0;
            b.last = 1'b0;
            mip_expected.insert(mip_expected.size(), b);
            produced++;
            pix = npix;
            lv++;
        end

        if (final_pixel)
        begin
            count = lvl_cols[0] * lvl_rows[0];
            b.level = 4'd0;
            b.column = '0;
            b.row = '0;
            avg = chan_sum[0] / count;
            b.red = (avg > 255) ? 8'hff : 8'(avg);
            avg = chan_sum[1] / count;
            b.green = (avg > 255) ? 8'hff : 8'(avg);
            avg = chan_sum[2] / count;
            b.blue = (avg > 255) ? 8'hff : 8'(avg);
            avg = chan_sum[3] / count;
            b.alpha = (avg > 255) ? 8'hff : 8'(avg);
            b.transparent = (b.alpha != 8'hff);
            b.last = 1'b0;
            mip_expected.insert(mip_expected.size(), b);
            produced++;
        end
        if (produced > 0)
            mip_expected[mip_expected.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: change at the falling edge, take the beat at the rising.
    // ------------------------------------------------------------------
    int unsigned send_gap;

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_mip_beats(s_axis_tdata);
            void'(pixel_queue.pop_front());
            pixels_sent++;
            pixel_taken <= 1'b1;
        end
    end

    always @(negedge clk)
    begin
        pixel_taken <= 1'b0;
        // Hold an offered beat until it is taken.
        if (!(s_axis_tvalid && !pixel_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pixel_queue.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(1, 11) - 1;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pixel_queue[0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts plus an occasional long hold-off.
    // ------------------------------------------------------------------
    int unsigned stall_left;
    int unsigned holds_served;

    always @(negedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result monitor: compare each beat with the oldest expectation.
    always @(posedge clk)
    begin
        mip_beat_t want;
        mip_beat_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.level = m_axis_tdata[3:0];
            got.column = m_axis_tdata[14:4];
            got.row = m_axis_tdata[25:15];
            got.red = m_axis_tdata[33:26];
            got.green = m_axis_tdata[41:34];
            got.blue = m_axis_tdata[49:42];
            got.alpha = m_axis_tdata[57:50];
            got.transparent = m_axis_tuser;
            got.last = m_axis_tlast;
            if (mip_expected.size() == 0)
            begin
                error_count++;
                $display("unexpected beat: level %0d col %0d row %0d",
                         got.level, got.column, got.row);
            end
            else
            begin
                want = mip_expected.pop_front();
                beats_checked++;
                if (want.level > deepest_level)
                    deepest_level = want.level;
                if (got.level !== want.level || got.column !== want.column ||
                    got.row !== want.row || got.red !== want.red ||
                    got.green !== want.green || got.blue !== want.blue ||
                    got.alpha !== want.alpha || got.transparent !== want.transparent ||
                    got.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch exp lv%0d c%0d r%0d rgba %h %h %h %h t%b l%b",
                                 want.level, want.column, want.row, want.red, want.green,
                                 want.blue, want.alpha, want.transparent, want.last);
                        $display("         got lv%0d c%0d r%0d rgba %h %h %h %h t%b l%b",
                                 got.level, got.column, got.row, got.red, got.green,
                                 got.blue, got.alpha, got.transparent, got.last);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || s_axis_tvalid || mip_expected.size() != 0)
            @(posedge clk);
        // A pixel with no result can still be in flight; let it drain.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [12:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(input logic [12:0] w, input logic [12:0] h);
        wait_idle();
        write_register(bfm_pkg::REG_WIDTH, w);
        write_register(bfm_pkg::REG_HEIGHT, h);
    endtask

    function automatic logic [31:0] random_pixel(input bit opaque);
        logic [31:0] p;
        p = $urandom;
        if (opaque || $urandom_range(0, 3) == 0)
            p[31:24] = 8'hff;
        return p;
    endfunction

    task automatic queue_pixels(input int unsigned n, input bit opaque);
        for (int i = 0; i < n; i++)
            pixel_queue.insert(pixel_queue.size(), random_pixel(opaque));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single pixel images: darkest and brightest, each closes its own image.
        set_size(13'd1, 13'd1);
        pixel_queue.insert(pixel_queue.size(), 32'h0000_0000);
        pixel_queue.insert(pixel_queue.size(), 32'hffff_ffff);
        // Write to an unused index: nothing should move.
        wait_idle();
        write_register(REG_SPARE, 13'(int'($urandom)));
        pixel_queue.insert(pixel_queue.size(), 32'h00ff_00ff);

        // Zero width behaves as one column.
        set_size(13'd0, 13'd3);
        pixel_queue.insert(pixel_queue.size(), 32'hff00_ff00);
        pixel_queue.insert(pixel_queue.size(), 32'hff80_7f01);
        pixel_queue.insert(pixel_queue.size(), 32'hfffe_0102);

        // Oversized widths clamp; abandon these images after a few pixels.
        set_size(13'h1fff, 13'd2);
        for (int i = 0; i < 6; i++)
            pixel_queue.insert(pixel_queue.size(), i[0] ? 32'hffff_ffff : 32'h0000_0000);
        set_size(13'd4096, 13'd4096);
        queue_pixels(4, 0);
        set_size(13'd4097, 13'd1);
        queue_pixels(3, 0);

        // Random images: two levels deep, with a long receiver hold-off up front.
        set_size(13'd10, 13'd10);
        hold_requests++;
        queue_pixels(100, 0);

        // Odd sizes drop the last column and row; fully opaque.
        set_size(13'd9, 13'd7);
        queue_pixels(63, 1);

        // Smallest size that still builds a level, two images back to back.
        set_size(13'd5, 13'd5);
        queue_pixels(50, 0);

        // Last stretch runs without idling.
        set_size(13'd13, 13'd6);
        quiet = 1'b1;
        queue_pixels(78, 0);

        wait_idle();
        $display("covered %0d pixels and %0d result beats, mip levels down to %0d",
                 pixels_sent, beats_checked, deepest_level);
        $display("mismatches %0d, unexpected beats %0d", mismatch_count, error_count);
        if (mismatch_count == 0 && error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
